@@ design/ips_pkg.sv @@
// ----------------------------------------------------------------------------
// Irrigation pump sequencer package
// Shared types, register indexes and mode codes of the pump sequencer.
// ----------------------------------------------------------------------------
package ips_pkg;

   localparam int MAX_SLOTS   = 4;
   localparam int CSR_INDEX_W = 3;
   localparam int VOL_W       = 20;
   localparam int TICK_W      = 16;
   localparam int DAY_W       = 16;
   localparam int FLOW_W      = 16;
   localparam int CODE_W      = 3;

   // Register indexes; slot n sits at CSR_SLOT0 + n.
   localparam logic [CSR_INDEX_W-1:0] CSR_SLOT0   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_NO_FLOW = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_RETRY   = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_LEAK    = 3'd6;

   localparam logic [TICK_W-1:0] RST_NO_FLOW = 16'd60;
   localparam logic [TICK_W-1:0] RST_RETRY   = 16'd600;
   localparam logic [VOL_W-1:0]  RST_LEAK    = 20'd500;

   // Flow at or below one litre per minute counts as no flow.
   localparam logic [FLOW_W-1:0] FLOW_MIN_ML = 16'd1000;
   localparam logic [TICK_W-1:0] TICK_MAX    = 16'hFFFF;

   localparam logic [CODE_W-1:0] MODE_CODE_IDLE   = 3'd0;
   localparam logic [CODE_W-1:0] MODE_CODE_MANUAL = 3'd1;
   localparam logic [CODE_W-1:0] MODE_CODE_WATER  = 3'd2;
   localparam logic [CODE_W-1:0] MODE_CODE_DELAY  = 3'd3;
   localparam logic [CODE_W-1:0] MODE_CODE_BLOCK  = 3'd4;

   typedef enum logic [4:0] {
      MODE_IDLE   = 5'b00001,
      MODE_MANUAL = 5'b00010,
      MODE_WATER  = 5'b00100,
      MODE_DELAY  = 5'b01000,
      MODE_BLOCK  = 5'b10000
   } mode_type;

   typedef struct packed {
      logic              enable;
      logic [4:0]        hour;
      logic [5:0]        minute;
      logic [VOL_W-1:0]  target_ml;
   } slot_type;

   typedef struct packed {
      logic [TICK_W-1:0] no_flow_ticks;
      logic [TICK_W-1:0] retry_ticks;
      logic [VOL_W-1:0]  leak_threshold_ml;
   } cfg_type;

   typedef struct packed {
      logic [4:0]        hour_now;
      logic [5:0]        minute_now;
      logic [DAY_W-1:0]  day_index;
      logic              time_valid;
      logic              paused;
      logic              manual_request;
      logic [FLOW_W-1:0] flow_ml_per_min;
      logic [VOL_W-1:0]  delivered_ml;
      logic [VOL_W-1:0]  target_ml;
   } req_type;

   typedef struct packed {
      logic              pump_on;
      logic [CODE_W-1:0] mode_code;
      logic              clear_volume;
      logic              load_target;
      logic [VOL_W-1:0]  new_target_ml;
      logic              clear_manual;
      logic              record_last;
      logic [VOL_W-1:0]  last_volume_ml;
      logic              shake_request;
      logic              save_request;
   } rsp_type;

   function automatic logic [CODE_W-1:0] mode_code(input mode_type m);
      logic [CODE_W-1:0] c;
      unique case (m)
         MODE_MANUAL: c = MODE_CODE_MANUAL;
         MODE_WATER:  c = MODE_CODE_WATER;
         MODE_DELAY:  c = MODE_CODE_DELAY;
         MODE_BLOCK:  c = MODE_CODE_BLOCK;
         default:     c = MODE_CODE_IDLE;
      endcase
      return c;
   endfunction

endpackage

@@ design/ips_csr.sv @@
// ----------------------------------------------------------------------------
// Pump sequencer configuration registers
// Holds the schedule slots, the flow and retry timeouts and the leak threshold.
// ----------------------------------------------------------------------------
module ips_csr #(
   parameter int NUM_SLOTS = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wen,
   input  logic [ips_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [31:0]                         csr_wdata,
   output ips_pkg::cfg_type                    cfg,
   output ips_pkg::slot_type                   slot_cfg [NUM_SLOTS]
);
   import ips_pkg::*;

   cfg_type  cfg_ff;
   slot_type slot_ff [NUM_SLOTS];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.no_flow_ticks     <= RST_NO_FLOW;
         cfg_ff.retry_ticks       <= RST_RETRY;
         cfg_ff.leak_threshold_ml <= RST_LEAK;
      end else if (csr_wen) begin
         if (csr_index == CSR_NO_FLOW) cfg_ff.no_flow_ticks <= csr_wdata[TICK_W-1:0];
         if (csr_index == CSR_RETRY)   cfg_ff.retry_ticks   <= csr_wdata[TICK_W-1:0];
         if (csr_index == CSR_LEAK)    cfg_ff.leak_threshold_ml <= csr_wdata[VOL_W-1:0];
      end
   end

   // Slot indexes at or above NUM_SLOTS have no register and are dropped.
   for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_slot
      always_ff @(posedge clock) begin
         if (reset) begin
            slot_ff[g] <= '0;
         end else if (csr_wen && csr_index == CSR_SLOT0 + CSR_INDEX_W'(g)) begin
            slot_ff[g] <= slot_type'(csr_wdata);
         end
      end
      assign slot_cfg[g] = slot_ff[g];
   end

   assign cfg = cfg_ff;

endmodule

@@ design/ips_fsm.sv @@
// ----------------------------------------------------------------------------
// Pump sequencer mode machine
// Holds the mode, flow timer, last watering day and slot done flags, and works
// out the result beat of one tick.
// ----------------------------------------------------------------------------
module ips_fsm #(
   parameter int NUM_SLOTS = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  ips_pkg::req_type     item,
   input  ips_pkg::cfg_type     cfg,
   input  ips_pkg::slot_type    slot_cfg [NUM_SLOTS],
   output ips_pkg::rsp_type     result
);
   import ips_pkg::*;

   mode_type                mode_ff,      mode_in;
   logic [DAY_W-1:0]        last_day_ff,  last_day_in;
   logic [TICK_W-1:0]       flow_idle_ff, flow_idle_in;
   logic [NUM_SLOTS-1:0]    slot_done_ff, slot_done_in;

   always_comb begin
      logic       found;
      logic [TICK_W-1:0] fic;

      result       = '0;
      mode_in      = mode_ff;
      last_day_in  = last_day_ff;
      slot_done_in = slot_done_ff;
      found        = 1'b0;

      if (item.flow_ml_per_min > FLOW_MIN_ML) begin
         fic = '0;
      end else if (flow_idle_ff != TICK_MAX) begin
         fic = flow_idle_ff + TICK_W'(1);
      end else begin
         fic = flow_idle_ff;
      end
      flow_idle_in = fic;

      unique case (mode_ff)
         MODE_MANUAL: begin
            if (!item.manual_request || item.delivered_ml >= item.target_ml) begin
               result.clear_manual   = 1'b1;
               result.record_last    = 1'b1;
               result.last_volume_ml = item.delivered_ml;
               result.clear_volume   = 1'b1;
               last_day_in           = item.day_index;
               mode_in               = MODE_IDLE;
            end
         end
         MODE_WATER: begin
            if (item.paused) begin
               mode_in = MODE_BLOCK;
            end else if (item.manual_request) begin
               result.clear_volume = 1'b1;
               mode_in             = MODE_MANUAL;
            end else if (item.target_ml <= item.delivered_ml) begin
               result.record_last    = 1'b1;
               result.last_volume_ml = item.delivered_ml;
               result.clear_volume   = 1'b1;
               result.save_request   = 1'b1;
               last_day_in           = item.day_index;
               mode_in               = MODE_IDLE;
            end else if (fic > cfg.no_flow_ticks) begin
               mode_in      = MODE_DELAY;
               flow_idle_in = '0;
            end
         end
         MODE_DELAY: begin
            if (item.paused) begin
               mode_in = MODE_BLOCK;
            end else if (item.manual_request) begin
               result.clear_volume = 1'b1;
               mode_in             = MODE_MANUAL;
            end else if (fic > cfg.retry_ticks) begin
               mode_in      = MODE_WATER;
               flow_idle_in = '0;
            end
         end
         MODE_BLOCK: begin
            // Leaving blocked for manual keeps the delivered volume.
            if (item.manual_request) begin
               mode_in = MODE_MANUAL;
            end else if (!item.paused) begin
               mode_in = MODE_IDLE;
            end
         end
         default: begin
            mode_in = MODE_IDLE;
            result.shake_request = item.delivered_ml > cfg.leak_threshold_ml;
            if (item.time_valid && item.day_index != last_day_ff) begin
               slot_done_in = '0;
               last_day_in  = item.day_index;
            end
            if (item.paused) begin
               mode_in = MODE_BLOCK;
            end else if (item.manual_request) begin
               result.clear_volume = 1'b1;
               mode_in             = MODE_MANUAL;
            end else begin
               // First enabled slot not yet run today whose time matches wins.
               for (int i = 0; i < NUM_SLOTS; i++) begin
                  if (!found && slot_cfg[i].enable && !slot_done_in[i] &&
                      slot_cfg[i].hour == item.hour_now &&
                      slot_cfg[i].minute == item.minute_now) begin
                     found               = 1'b1;
                     slot_done_in[i]     = 1'b1;
                     result.load_target  = 1'b1;
                     result.new_target_ml = slot_cfg[i].target_ml;
                     result.clear_volume = 1'b1;
                     flow_idle_in        = '0;
                     mode_in             = MODE_WATER;
                  end
               end
            end
         end
      endcase

      result.pump_on   = (mode_in == MODE_WATER) || (mode_in == MODE_MANUAL);
      result.mode_code = mode_code(mode_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_IDLE;
         last_day_ff  <= '0;
         flow_idle_ff <= '0;
         slot_done_ff <= '0;
      end else if (advance) begin
         mode_ff      <= mode_in;
         last_day_ff  <= last_day_in;
         flow_idle_ff <= flow_idle_in;
         slot_done_ff <= slot_done_in;
      end
   end

endmodule

@@ design/irrigation_pump_sequencer_unit.sv @@
// ----------------------------------------------------------------------------
// Irrigation pump sequencer unit
// A request beat passes the input register, then the mode update into the
// response register. Throughput: one tick per cycle while rsp_ready is high;
// the input register refills while a finished response waits for rsp_ready.
// Synchronous reset returns the mode to idle, clears the day, flow timer and
// slot done flags and loads register defaults.
// ----------------------------------------------------------------------------
module irrigation_pump_sequencer_unit #(
   parameter int NUM_SLOTS = 4
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wen,
   input  logic [ips_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [31:0]                      csr_wdata,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [4:0]                       req_hour_now,
   input  logic [5:0]                       req_minute_now,
   input  logic [15:0]                      req_day_index,
   input  logic                             req_time_valid,
   input  logic                             req_paused,
   input  logic                             req_manual_request,
   input  logic [15:0]                      req_flow_ml_per_min,
   input  logic [19:0]                      req_delivered_ml,
   input  logic [19:0]                      req_target_ml,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_pump_on,
   output logic [2:0]                       rsp_mode_code,
   output logic                             rsp_clear_volume,
   output logic                             rsp_load_target,
   output logic [19:0]                      rsp_new_target_ml,
   output logic                             rsp_clear_manual,
   output logic                             rsp_record_last,
   output logic [19:0]                      rsp_last_volume_ml,
   output logic                             rsp_shake_request,
   output logic                             rsp_save_request
);
   import ips_pkg::*;

   cfg_type  cfg;
   slot_type slot_cfg [NUM_SLOTS];
   req_type  req_ff,  req_in;
   rsp_type  rsp_ff,  rsp_in;
   logic     req_valid_ff;
   logic     rsp_valid_ff;
   logic     advance;

   ips_csr #(.NUM_SLOTS(NUM_SLOTS)) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg),
      .slot_cfg  (slot_cfg)
   );

   ips_fsm #(.NUM_SLOTS(NUM_SLOTS)) u_fsm (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .item     (req_ff),
      .cfg      (cfg),
      .slot_cfg (slot_cfg),
      .result   (rsp_in)
   );

   assign advance   = req_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !req_valid_ff || advance;

   assign req_in = '{
      hour_now:        req_hour_now,
      minute_now:      req_minute_now,
      day_index:       req_day_index,
      time_valid:      req_time_valid,
      paused:          req_paused,
      manual_request:  req_manual_request,
      flow_ml_per_min: req_flow_ml_per_min,
      delivered_ml:    req_delivered_ml,
      target_ml:       req_target_ml
   };

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_ready) req_valid_ff <= req_valid;
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) req_ff <= req_in;
      if (advance) rsp_ff <= rsp_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_pump_on        = rsp_ff.pump_on;
   assign rsp_mode_code      = rsp_ff.mode_code;
   assign rsp_clear_volume   = rsp_ff.clear_volume;
   assign rsp_load_target    = rsp_ff.load_target;
   assign rsp_new_target_ml  = rsp_ff.new_target_ml;
   assign rsp_clear_manual   = rsp_ff.clear_manual;
   assign rsp_record_last    = rsp_ff.record_last;
   assign rsp_last_volume_ml = rsp_ff.last_volume_ml;
   assign rsp_shake_request  = rsp_ff.shake_request;
   assign rsp_save_request   = rsp_ff.save_request;

   // A scheduled start always lands in watering.
   a_load_means_water: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_load_target |-> rsp_mode_code == MODE_CODE_WATER)
      else $error("target load without a move to watering");

   // A finished session returns to idle and clears the volume counter.
   a_record_means_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_record_last |-> rsp_mode_code == MODE_CODE_IDLE && rsp_clear_volume)
      else $error("session record without idle and volume clear");

   a_pump_follows_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_pump_on == (rsp_mode_code == MODE_CODE_WATER ||
                                    rsp_mode_code == MODE_CODE_MANUAL))
      else $error("pump drive disagrees with mode");

   a_target_zero_unless_load: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_load_target |-> rsp_new_target_ml == '0)
      else $error("new target set without a load");

   // A stalled request beat moves into the mode machine once the response slot frees.
   a_stage_moves: assert property (@(posedge clock) disable iff (reset)
      req_valid_ff && !rsp_valid_ff |=> rsp_valid_ff)
      else $error("held request beat did not produce a response");

endmodule

@@ tb/tb_irrigation_pump_sequencer_unit.sv @@
// ----------------------------------------------------------------------------
// Irrigation pump sequencer unit testbench
// Drives control ticks through the request channel and checks every response
// beat against a cycle-free model of the mode machine kept in the bench. A
// directed opening walks the session, retry, manual and pause paths; random
// phases then vary the registers and the idling of both channels.
// ----------------------------------------------------------------------------
module tb_irrigation_pump_sequencer_unit;
   import ips_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASE_TICKS = 244;
   localparam int NUM_PHASES  = 8;
   localparam int SLOT_IDX_W  = $clog2(MAX_SLOTS);
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 3'd7;
   localparam logic [VOL_W-1:0] VOL_MAX = 20'hFFFFF;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_wen = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [31:0]            csr_wdata = '0;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [4:0]             req_hour_now = '0;
   logic [5:0]             req_minute_now = '0;
   logic [15:0]            req_day_index = '0;
   logic                   req_time_valid = 1'b0;
   logic                   req_paused = 1'b0;
   logic                   req_manual_request = 1'b0;
   logic [15:0]            req_flow_ml_per_min = '0;
   logic [19:0]            req_delivered_ml = '0;
   logic [19:0]            req_target_ml = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic                   rsp_pump_on;
   logic [2:0]             rsp_mode_code;
   logic                   rsp_clear_volume;
   logic                   rsp_load_target;
   logic [19:0]            rsp_new_target_ml;
   logic                   rsp_clear_manual;
   logic                   rsp_record_last;
   logic [19:0]            rsp_last_volume_ml;
   logic                   rsp_shake_request;
   logic                   rsp_save_request;

   irrigation_pump_sequencer_unit u_top (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Bench copy of the registers and the sequencer state.
   slot_type          slot_cfg [MAX_SLOTS];
   logic [TICK_W-1:0] no_flow_limit;
   logic [TICK_W-1:0] retry_limit;
   logic [VOL_W-1:0]  leak_limit;
   mode_type          seq_mode;
   logic [DAY_W-1:0]  watered_day;
   logic [TICK_W-1:0] dry_ticks;
   logic [MAX_SLOTS-1:0] slot_done;

   req_type tick_queue [$];
   rsp_type predicted_rsp [$];
   int      req_gap_pct = 0;
   int      rsp_stall_pct = 0;
   int      mismatch_count = 0;
   int      rsp_beats = 0;
   int      cycle_count = 0;

   // Environment seen by the random tick generator.
   logic [DAY_W-1:0]  gen_day = 16'd100;
   logic              gen_paused = 1'b0;
   logic              gen_manual = 1'b0;
   logic              gen_flow_high = 1'b1;
   int                gen_flow_run = 0;
   logic [VOL_W-1:0]  gen_delivered = '0;
   logic [VOL_W-1:0]  gen_target = 20'd500;

   task automatic advance_sequencer(input req_type t, output rsp_type o);
      logic found;
      o = '0;
      found = 1'b0;
      if (t.flow_ml_per_min > FLOW_MIN_ML) dry_ticks = '0;
      else if (dry_ticks != TICK_MAX) dry_ticks = dry_ticks + 1'b1;

      case (seq_mode)
         MODE_MANUAL: begin
            if (!t.manual_request || t.delivered_ml >= t.target_ml) begin
               o.clear_manual = 1'b1;
               o.record_last = 1'b1;
               o.last_volume_ml = t.delivered_ml;
               o.clear_volume = 1'b1;
               watered_day = t.day_index;
               seq_mode = MODE_IDLE;
            end
         end
         MODE_WATER, MODE_DELAY: begin
            if (t.paused) begin
               seq_mode = MODE_BLOCK;
            end else if (t.manual_request) begin
               o.clear_volume = 1'b1;
               seq_mode = MODE_MANUAL;
            end else if (seq_mode == MODE_WATER) begin
               if (t.target_ml <= t.delivered_ml) begin
                  o.record_last = 1'b1;
                  o.last_volume_ml = t.delivered_ml;
                  o.clear_volume = 1'b1;
                  o.save_request = 1'b1;
                  watered_day = t.day_index;
                  seq_mode = MODE_IDLE;
               end else if (dry_ticks > no_flow_limit) begin
                  seq_mode = MODE_DELAY;
                  dry_ticks = '0;
               end
            end else if (dry_ticks > retry_limit) begin
               seq_mode = MODE_WATER;
               dry_ticks = '0;
            end
         end
         MODE_BLOCK: begin
            // Leaving a pause straight into manual does not clear the volume.
            if (!t.paused) seq_mode = MODE_IDLE;
            if (t.manual_request) seq_mode = MODE_MANUAL;
         end
         default: begin
            seq_mode = MODE_IDLE;
            if (t.delivered_ml > leak_limit) o.shake_request = 1'b1;
            if (t.time_valid && t.day_index != watered_day) begin
               slot_done = '0;
               watered_day = t.day_index;
            end
            if (t.paused) begin
               seq_mode = MODE_BLOCK;
            end else if (t.manual_request) begin
               o.clear_volume = 1'b1;
               seq_mode = MODE_MANUAL;
            end else begin
               for (int i = 0; i < MAX_SLOTS; i++) begin
                  if (!found && slot_cfg[i].enable && !slot_done[i] &&
                      slot_cfg[i].hour == t.hour_now &&
                      slot_cfg[i].minute == t.minute_now) begin
                     found = 1'b1;
                     slot_done[i] = 1'b1;
                     o.load_target = 1'b1;
                     o.new_target_ml = slot_cfg[i].target_ml;
                     o.clear_volume = 1'b1;
                     dry_ticks = '0;
                     seq_mode = MODE_WATER;
                  end
               end
            end
         end
      endcase

      o.pump_on = (seq_mode == MODE_WATER || seq_mode == MODE_MANUAL);
      case (seq_mode)
         MODE_MANUAL: o.mode_code = MODE_CODE_MANUAL;
         MODE_WATER:  o.mode_code = MODE_CODE_WATER;
         MODE_DELAY:  o.mode_code = MODE_CODE_DELAY;
         MODE_BLOCK:  o.mode_code = MODE_CODE_BLOCK;
         default:     o.mode_code = MODE_CODE_IDLE;
      endcase
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [31:0] val);
      @(posedge clock);
      csr_wen <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wen <= 1'b0;
      if (idx < CSR_NO_FLOW) slot_cfg[SLOT_IDX_W'(idx - CSR_SLOT0)] = val;
      else if (idx == CSR_NO_FLOW) no_flow_limit = val[TICK_W-1:0];
      else if (idx == CSR_RETRY) retry_limit = val[TICK_W-1:0];
      else if (idx == CSR_LEAK) leak_limit = val[VOL_W-1:0];
   endtask

   function automatic slot_type random_slot();
      slot_type s;
      if ($urandom_range(99) < 8) return slot_type'($urandom);
      s.enable = ($urandom_range(99) < 85);
      s.hour = ($urandom_range(99) < 10) ? 5'($urandom_range(31, 24)) : 5'($urandom_range(23));
      s.minute = ($urandom_range(99) < 10) ? 6'($urandom_range(63, 60))
                                           : 6'($urandom_range(59));
      case ($urandom_range(9))
         0:       s.target_ml = '0;
         1:       s.target_ml = VOL_MAX;
         default: s.target_ml = 20'($urandom_range(3000));
      endcase
      return s;
   endfunction

   task automatic program_phase(input int p);
      slot_type s0;
      slot_type s1;
      s0 = random_slot();
      s1 = random_slot();
      // Two slots at the same time: the lower one must win.
      if ($urandom_range(2) == 0) begin
         s1.hour = s0.hour;
         s1.minute = s0.minute;
      end
      write_csr(CSR_SLOT0, s0);
      write_csr(CSR_SLOT0 + 3'd1, s1);
      write_csr(CSR_SLOT0 + 3'd2, random_slot());
      write_csr(CSR_SLOT0 + 3'd3, random_slot());
      case (p)
         0: begin
            write_csr(CSR_NO_FLOW, '0);
            write_csr(CSR_RETRY, '0);
            write_csr(CSR_LEAK, '0);
         end
         1: begin
            write_csr(CSR_NO_FLOW, 32'(TICK_MAX));
            write_csr(CSR_RETRY, 32'(TICK_MAX));
            write_csr(CSR_LEAK, 32'(VOL_MAX));
         end
         2: begin
            write_csr(CSR_NO_FLOW, 32'(RST_NO_FLOW));
            write_csr(CSR_RETRY, 32'(RST_RETRY));
            write_csr(CSR_LEAK, 32'(RST_LEAK));
         end
         default: begin
            write_csr(CSR_NO_FLOW, $urandom_range(20));
            write_csr(CSR_RETRY, $urandom_range(30));
            write_csr(CSR_LEAK, $urandom_range(3000));
         end
      endcase
   endtask

   task automatic queue_tick(input int hr, mn, day, tv, pz, man, flow, dlv, tgt);
      req_type t;
      t.hour_now = 5'(hr);
      t.minute_now = 6'(mn);
      t.day_index = 16'(day);
      t.time_valid = 1'(tv);
      t.paused = 1'(pz);
      t.manual_request = 1'(man);
      t.flow_ml_per_min = 16'(flow);
      t.delivered_ml = 20'(dlv);
      t.target_ml = 20'(tgt);
      tick_queue.push_back(t);
   endtask

   task automatic queue_random_tick();
      req_type t;
      slot_type s;
      int r;
      if ($urandom_range(99) < 3) begin
         t = req_type'(($bits(req_type))'({$urandom, $urandom, $urandom}));
         t.hour_now = 5'($urandom_range(23));
         t.minute_now = 6'($urandom_range(59));
         tick_queue.push_back(t);
         return;
      end
      // Follow one of the slots often, so that scheduled starts happen.
      s = slot_cfg[SLOT_IDX_W'($urandom_range(MAX_SLOTS - 1))];
      if ($urandom_range(99) < 45 && s.hour <= 23 && s.minute <= 59) begin
         t.hour_now = s.hour;
         t.minute_now = s.minute;
      end else begin
         t.hour_now = 5'($urandom_range(23));
         t.minute_now = 6'($urandom_range(59));
      end
      r = $urandom_range(99);
      if (r < 12) gen_day = gen_day + 1'b1;
      else if (r < 14) gen_day = 16'($urandom);
      t.day_index = gen_day;
      t.time_valid = ($urandom_range(99) < 85);
      if (gen_paused) gen_paused = ($urandom_range(99) >= 25);
      else gen_paused = ($urandom_range(99) < 3);
      if (gen_manual) gen_manual = ($urandom_range(99) >= 10);
      else gen_manual = ($urandom_range(99) < 5);
      t.paused = gen_paused;
      t.manual_request = gen_manual;

      // Flow comes in runs, long enough to reach the no-flow and retry limits.
      if (gen_flow_run == 0) begin
         gen_flow_high = 1'($urandom_range(1));
         gen_flow_run = $urandom_range(40, 1);
      end
      gen_flow_run--;
      r = $urandom_range(9);
      if (gen_flow_high)
         t.flow_ml_per_min = (r == 0) ? 16'd1001 : (r == 1) ? 16'hFFFF :
                             (r < 6) ? 16'($urandom_range(3000, 1001))
                                     : 16'($urandom_range(65535, 1001));
      else
         t.flow_ml_per_min = (r < 2) ? 16'd0 : (r < 4) ? 16'd1000 : 16'($urandom_range(1000));

      r = $urandom_range(99);
      if (r < 5) begin
         r = $urandom_range(9);
         gen_target = (r == 0) ? '0 : (r == 1) ? VOL_MAX :
                      (r == 2) ? 20'($urandom) : 20'($urandom_range(3000));
      end
      r = $urandom_range(99);
      if (r < 60) gen_delivered = gen_delivered + 20'($urandom_range(300));
      else if (r < 70) gen_delivered = '0;
      else if (r < 80) gen_delivered = gen_target;
      else if (r < 85) gen_delivered = 20'($urandom);
      t.delivered_ml = gen_delivered;
      t.target_ml = gen_target;
      tick_queue.push_back(t);
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (tick_queue.size() != 0 || req_valid || predicted_rsp.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic compare_field(input string name, input logic [VOL_W-1:0] want, got);
      if (want !== got) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("beat %0d: %s expected %0h, got %0h", rsp_beats, name, want, got);
      end
   endtask

   always @(posedge clock) begin : drive_ticks
      req_type cur;
      rsp_type want;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            cur.hour_now = req_hour_now;
            cur.minute_now = req_minute_now;
            cur.day_index = req_day_index;
            cur.time_valid = req_time_valid;
            cur.paused = req_paused;
            cur.manual_request = req_manual_request;
            cur.flow_ml_per_min = req_flow_ml_per_min;
            cur.delivered_ml = req_delivered_ml;
            cur.target_ml = req_target_ml;
            advance_sequencer(cur, want);
            predicted_rsp.push_back(want);
         end
         if (!req_valid || req_ready) begin
            if (tick_queue.size() != 0 && $urandom_range(99) >= req_gap_pct) begin
               cur = tick_queue.pop_front();
               req_hour_now <= cur.hour_now;
               req_minute_now <= cur.minute_now;
               req_day_index <= cur.day_index;
               req_time_valid <= cur.time_valid;
               req_paused <= cur.paused;
               req_manual_request <= cur.manual_request;
               req_flow_ml_per_min <= cur.flow_ml_per_min;
               req_delivered_ml <= cur.delivered_ml;
               req_target_ml <= cur.target_ml;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : watch_responses
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            rsp_beats++;
            if (predicted_rsp.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("beat %0d: response beat with nothing predicted", rsp_beats);
            end else begin
               want = predicted_rsp.pop_front();
               compare_field("pump_on", VOL_W'(want.pump_on), VOL_W'(rsp_pump_on));
               compare_field("mode_code", VOL_W'(want.mode_code), VOL_W'(rsp_mode_code));
               compare_field("clear_volume", VOL_W'(want.clear_volume),
                             VOL_W'(rsp_clear_volume));
               compare_field("load_target", VOL_W'(want.load_target),
                             VOL_W'(rsp_load_target));
               compare_field("new_target_ml", want.new_target_ml, rsp_new_target_ml);
               compare_field("clear_manual", VOL_W'(want.clear_manual),
                             VOL_W'(rsp_clear_manual));
               compare_field("record_last", VOL_W'(want.record_last),
                             VOL_W'(rsp_record_last));
               compare_field("last_volume_ml", want.last_volume_ml, rsp_last_volume_ml);
               compare_field("shake_request", VOL_W'(want.shake_request),
                             VOL_W'(rsp_shake_request));
               compare_field("save_request", VOL_W'(want.save_request),
                             VOL_W'(rsp_save_request));
            end
         end
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < MAX_SLOTS; i++) slot_cfg[i] = '0;
      no_flow_limit = RST_NO_FLOW;
      retry_limit = RST_RETRY;
      leak_limit = RST_LEAK;
      seq_mode = MODE_IDLE;
      watered_day = '0;
      dry_ticks = '0;
      slot_done = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Slot one can never match (hour out of range); slot three is disabled.
      write_csr(CSR_SLOT0, {1'b1, 5'd6, 6'd30, 20'd1000});
      write_csr(CSR_SLOT0 + 3'd1, {1'b1, 5'd31, 6'd0, 20'd5});
      write_csr(CSR_SLOT0 + 3'd2, {1'b1, 5'd23, 6'd59, VOL_MAX});
      write_csr(CSR_SLOT0 + 3'd3, {1'b0, 5'd6, 6'd30, 20'd7});
      write_csr(CSR_NO_FLOW, 32'd2);
      write_csr(CSR_RETRY, 32'd3);
      write_csr(CSR_LEAK, 32'd0);
      write_csr(CSR_UNUSED, 32'hFFFF_FFFF);

      queue_tick(0, 0, 5, 1, 0, 0, 65535, 0, 0);
      queue_tick(0, 0, 5, 1, 0, 0, 0, 1, 0);
      queue_tick(6, 30, 5, 1, 0, 0, 0, 0, 1000);
      repeat (3) queue_tick(6, 31, 5, 1, 0, 0, 0, 0, 1000);
      repeat (4) queue_tick(6, 31, 5, 1, 0, 0, 1000, 0, 1000);
      queue_tick(6, 32, 5, 1, 0, 0, 1001, 1000, 1000);
      queue_tick(6, 30, 5, 1, 0, 0, 1001, 0, 1000);
      repeat (2) queue_tick(6, 30, 5, 1, 1, 1, 0, 0, 0);
      queue_tick(7, 0, 5, 1, 0, 1, 2000, 5, 10);
      queue_tick(7, 0, 5, 1, 0, 1, 2000, 10, 10);
      queue_tick(7, 0, 5, 1, 0, 1, 2000, 0, 10);
      queue_tick(7, 0, 5, 1, 0, 0, 2000, 3, 10);
      queue_tick(23, 59, 65535, 0, 0, 0, 65535, 0, 0);
      queue_tick(23, 59, 65535, 0, 0, 1, 65535, 0, int'(VOL_MAX));
      queue_tick(23, 59, 65535, 0, 0, 1, 0, int'(VOL_MAX), int'(VOL_MAX));
      queue_tick(23, 59, 65535, 1, 0, 0, 0, int'(VOL_MAX), int'(VOL_MAX));
      queue_tick(23, 59, 0, 1, 0, 0, 0, 0, 0);
      queue_tick(23, 59, 0, 1, 1, 0, 0, 0, 5);
      queue_tick(23, 59, 0, 1, 0, 0, 0, 0, 5);
      wait_drained();

      for (int p = 0; p < NUM_PHASES; p++) begin
         program_phase(p);
         case (p % 4)
            0: begin req_gap_pct = 0;  rsp_stall_pct = 0;  end
            1: begin req_gap_pct = 59; rsp_stall_pct = 0;  end
            2: begin req_gap_pct = 0;  rsp_stall_pct = 59; end
            default: begin req_gap_pct = 13; rsp_stall_pct = 13; end
         endcase
         for (int n = 0; n < PHASE_TICKS; n++) queue_random_tick();
         wait_drained();
      end

      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && predicted_rsp.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

@@ sim.f @@
design/ips_pkg.sv
design/ips_csr.sv
design/ips_fsm.sv
design/irrigation_pump_sequencer_unit.sv
tb/tb_irrigation_pump_sequencer_unit.sv
